/* hw/rtl/tle_pkg.sv */
// Package: shared types, constants and event codes of the terminal line editor.
package tle_pkg;
    localparam int LINE_LEN      = 32;
    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_SLOTS    = HISTORY_DEPTH - 1;
    localparam int LW            = $clog2(LINE_LEN);
    localparam int SW            = $clog2(HIST_SLOTS);
    localparam int BW            = $clog2(HISTORY_DEPTH + 1);
    localparam int HAW           = $clog2(HIST_SLOTS * LINE_LEN);

    localparam logic [3:0] EV_NONE  = 4'd0;
    localparam logic [3:0] EV_EDIT  = 4'd1;
    localparam logic [3:0] EV_RIGHT = 4'd2;
    localparam logic [3:0] EV_LEFT  = 4'd3;
    localparam logic [3:0] EV_CMD   = 4'd4;
    localparam logic [3:0] EV_EMPTY = 4'd5;
    localparam logic [3:0] EV_ABORT = 4'd6;
    localparam logic [3:0] EV_CLEAR = 4'd7;
    localparam logic [3:0] EV_HOOK_UP = 4'd8;
    localparam logic [3:0] EV_HOOK_DN = 4'd9;
    localparam logic [3:0] EV_HOOK_RT = 4'd10;
    localparam logic [3:0] EV_HOOK_LT = 4'd11;

    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_DEL  = 8'd127;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_LBR  = 8'h5b;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_TILDE= 8'h7e;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_D    = 8'h44;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] out_char;
        logic [4:0] line_length;
        logic [4:0] cursor_pos;
        logic       last;
    } t_res;
endpackage

/* hw/rtl/tle_if.sv */
// Interfaces: byte input, config write and result channels.
interface tle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] arrow_hook_mask;
    modport source (output valid, output arrow_hook_mask, input ready);
    modport sink   (input valid, input arrow_hook_mask, output ready);
endinterface

interface tle_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic [7:0] out_char;
    logic [4:0] line_length;
    logic [4:0] cursor_pos;
    logic       last;
    modport source (output valid, output event_res, output out_char,
                    output line_length, output cursor_pos, output last, input ready);
    modport sink   (input valid, input event_res, input out_char,
                    input line_length, input cursor_pos, input last, output ready);
endinterface

/* hw/rtl/tle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/terminal_line_editor_with_history_top.sv */
// Top level: terminal line editor with escape parser and command history.
//
// Takes one terminal byte per beat and returns one or more result beats per
// byte. Line edits run as a sequencer over the line RAM: a simple byte
// (arrow, abort, tab, escape step) goes straight to the result state; insert,
// backspace and delete shift the tail one byte at a time through a read state
// and a write state; a history load copies one byte at a time the same way;
// enter emits one result per line byte while copying it into the history RAM,
// with a read state and an emit state per byte. The cost is set by the single
// read port of each RAM. Config writes are taken whenever offered.
module terminal_line_editor_with_history_top
    import tle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tle_byte_if.sink   s_in,
    tle_cfg_if.sink    s_cfg,
    tle_res_if.source  m_out
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHR_R = 4'd1;  // insert: read i-1
    localparam logic [3:0] S_SHR_W = 4'd2;  // insert: write i
    localparam logic [3:0] S_SHL_R = 4'd3;  // remove: read i+1
    localparam logic [3:0] S_SHL_W = 4'd4;  // remove: write i
    localparam logic [3:0] S_LD_R  = 4'd5;  // history load read
    localparam logic [3:0] S_LD_W  = 4'd6;  // history load write
    localparam logic [3:0] S_EN_R  = 4'd7;  // enter read
    localparam logic [3:0] S_EN_W  = 4'd8;  // enter emit/copy
    localparam logic [3:0] S_OUT   = 4'd9;  // single result
    localparam logic [3:0] S_WAIT  = 4'd10; // wait out drain

    logic [3:0]     r_st, n_st;
    logic [LW-1:0]  r_len, n_len, r_cur, n_cur;
    logic [LW:0]    r_i, n_i;       // loop index
    logic [LW-1:0]  r_n, n_n;       // loop end / total
    logic [SW-1:0]  r_head, n_head, r_slot, n_slot;
    logic [BW-1:0]  r_browse, n_browse;
    logic [1:0]     r_esc, n_esc;
    logic [3:0]     r_mask;
    logic [LW-1:0]  r_hlen [HIST_SLOTS];
    logic [7:0]     r_b, n_b;
    logic [3:0]     r_ev, n_ev;
    logic           r_ov, n_ov;
    t_res           r_o, n_o;
    logic           r_shr_ins, n_shr_ins;

    // line RAM
    logic           l_we;
    logic [LW-1:0]  l_wa, l_ra;
    logic [7:0]     l_wd, l_rd;
    // history RAM
    logic           h_we;
    logic [HAW-1:0] h_wa, h_ra;
    logic [7:0]     h_rd;

    tle_ram #(.WIDTH(8), .DEPTH(LINE_LEN)) u_line (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_wa), .i_wdata(l_wd),
        .i_raddr(l_ra), .o_rdata(l_rd));
    tle_ram #(.WIDTH(8), .DEPTH(HIST_SLOTS * LINE_LEN)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(l_rd),
        .i_raddr(h_ra), .o_rdata(h_rd));

    assign s_cfg.ready = 1'b1;
    assign s_in.ready  = (r_st == S_IDLE);
    assign m_out.valid = r_ov;
    assign m_out.event_res   = r_o.event_res;
    assign m_out.out_char    = r_o.out_char;
    assign m_out.line_length = r_o.line_length;
    assign m_out.cursor_pos  = r_o.cursor_pos;
    assign m_out.last        = r_o.last;

    logic o_free;
    assign o_free = !r_ov || m_out.ready;

    // history slot for an age (age 1..HIST_SLOTS)
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] head,
                                             input logic [BW-1:0] age);
        logic [SW:0] t;
        t = {1'b0, head} + (SW+1)'(HIST_SLOTS) - (SW+1)'(age);
        if (t >= (SW+1)'(HIST_SLOTS)) t = t - (SW+1)'(HIST_SLOTS);
        return t[SW-1:0];
    endfunction

    function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s,
                                             input logic [LW:0] i);
        return HAW'(s) * HAW'(LINE_LEN) + HAW'(i[LW-1:0]);
    endfunction

    logic [SW-1:0] up_slot, dn_slot;
    assign up_slot = slot_of(r_head, r_browse);
    assign dn_slot = slot_of(r_head, r_browse - BW'(2));

    always_comb begin
        n_st = r_st; n_len = r_len; n_cur = r_cur; n_i = r_i; n_n = r_n;
        n_head = r_head; n_slot = r_slot; n_browse = r_browse; n_esc = r_esc;
        n_b = r_b; n_ev = r_ev; n_o = r_o; n_shr_ins = r_shr_ins;
        n_ov = r_ov && !m_out.ready;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
        h_we = 1'b0; h_wa = '0; h_ra = '0;
        case (r_st)
            S_IDLE: begin
                if (s_in.valid) begin
                    n_b = s_in.rx_byte;
                    n_ev = EV_NONE;
                    n_st = S_OUT;
                    if (s_in.rx_byte == CH_BS || s_in.rx_byte == CH_DEL) begin
                        n_browse = BW'(1);
                        if (r_cur != '0) begin
                            n_i = (LW+1)'(r_cur) - 1'b1;
                            n_ev = EV_EDIT;
                            n_st = S_SHL_R;
                        end
                    end else if (s_in.rx_byte == CH_CR) begin
                        n_browse = BW'(1);
                        n_n = r_len;
                        n_len = '0; n_cur = '0;
                        if (r_len == '0) begin
                            n_ev = EV_EMPTY;
                        end else begin
                            n_i = '0;
                            n_slot = r_head;
                            n_head = (r_head == SW'(HIST_SLOTS - 1)) ? '0 : r_head + 1'b1;
                            n_st = S_EN_R;
                        end
                    end else if (s_in.rx_byte == CH_ESC) begin
                        n_esc = 2'd1;
                    end else if (r_esc == 2'd1) begin
                        n_esc = (s_in.rx_byte == CH_LBR) ? 2'd2 : 2'd0;
                    end else if (r_esc == 2'd2) begin
                        n_esc = 2'd0;
                        case (s_in.rx_byte)
                            CH_A: begin
                                if (r_mask[0]) n_ev = EV_HOOK_UP;
                                else if (r_browse < BW'(HISTORY_DEPTH)
                                         && r_hlen[up_slot] != '0) begin
                                    n_slot = up_slot;
                                    n_n = r_hlen[up_slot];
                                    n_i = '0;
                                    n_browse = r_browse + 1'b1;
                                    n_ev = EV_EDIT;
                                    n_st = S_LD_R;
                                end
                            end
                            CH_B: begin
                                if (r_mask[1]) n_ev = EV_HOOK_DN;
                                else if (r_browse > BW'(2)) begin
                                    n_browse = r_browse - 1'b1;
                                    n_slot = dn_slot;
                                    n_n = r_hlen[dn_slot];
                                    n_i = '0;
                                    n_ev = EV_EDIT;
                                    n_st = S_LD_R;
                                end else if (r_browse == BW'(2)) begin
                                    n_len = '0; n_cur = '0;
                                    n_browse = BW'(1);
                                    n_ev = EV_CLEAR;
                                end
                            end
                            CH_C: begin
                                if (r_mask[2]) n_ev = EV_HOOK_RT;
                                else if (r_cur < r_len) begin
                                    n_cur = r_cur + 1'b1; n_ev = EV_RIGHT;
                                end
                            end
                            CH_D: begin
                                if (r_mask[3]) n_ev = EV_HOOK_LT;
                                else if (r_cur != '0) begin
                                    n_cur = r_cur - 1'b1; n_ev = EV_LEFT;
                                end
                            end
                            CH_3: n_esc = 2'd3;
                            default: ;
                        endcase
                    end else if (r_esc == 2'd3) begin
                        n_esc = 2'd0;
                        if (s_in.rx_byte == CH_TILDE) begin
                            n_browse = BW'(1);
                            if (r_cur < r_len) begin
                                n_i = (LW+1)'(r_cur);
                                n_ev = EV_EDIT;
                                n_st = S_SHL_R;
                                n_shr_ins = 1'b1; // marks delete: cursor stays
                            end
                        end
                    end else if (s_in.rx_byte == CH_TAB) begin
                        n_ev = EV_NONE;
                    end else if (s_in.rx_byte == CH_ETX) begin
                        n_browse = BW'(1);
                        n_len = '0; n_cur = '0;
                        n_ev = EV_ABORT;
                    end else begin
                        n_browse = BW'(1);
                        n_i = (LW+1)'(r_len);
                        n_ev = EV_EDIT;
                        n_st = S_SHR_R;
                    end
                end
            end
            // insert: shift right from len down to cursor, then write byte
            S_SHR_R: begin
                if (r_i > (LW+1)'(r_cur)) begin
                    l_ra = LW'(r_i - 1'b1);
                    n_st = S_SHR_W;
                end else begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = r_b;
                    if (r_len != LW'(LINE_LEN - 1)) n_len = r_len + 1'b1;
                    if (r_cur != LW'(LINE_LEN - 1)) n_cur = r_cur + 1'b1;
                    n_st = S_OUT;
                end
            end
            S_SHR_W: begin
                l_we = (r_i < (LW+1)'(LINE_LEN));
                l_wa = LW'(r_i); l_wd = l_rd;
                n_i = r_i - 1'b1;
                n_st = S_SHR_R;
            end
            // remove at r_i: shift left up to len-1
            S_SHL_R: begin
                if (r_i + 1'b1 < (LW+1)'(r_len)) begin
                    l_ra = LW'(r_i + 1'b1);
                    n_st = S_SHL_W;
                end else begin
                    n_len = r_len - 1'b1;
                    if (!r_shr_ins) n_cur = r_cur - 1'b1;
                    n_shr_ins = 1'b0;
                    n_st = S_OUT;
                end
            end
            S_SHL_W: begin
                l_we = 1'b1; l_wa = LW'(r_i); l_wd = l_rd;
                n_i = r_i + 1'b1;
                n_st = S_SHL_R;
            end
            // history load: copy n bytes of slot into line
            S_LD_R: begin
                if (r_i < (LW+1)'(r_n)) begin
                    h_ra = haddr(r_slot, r_i);
                    n_st = S_LD_W;
                end else begin
                    n_len = r_n; n_cur = r_n;
                    n_st = S_OUT;
                end
            end
            S_LD_W: begin
                l_we = 1'b1; l_wa = LW'(r_i); l_wd = h_rd;
                n_i = r_i + 1'b1;
                n_st = S_LD_R;
            end
            // enter: read each byte, emit it and copy to history
            S_EN_R: begin
                l_ra = LW'(r_i);
                n_st = S_EN_W;
            end
            S_EN_W: begin
                if (o_free) begin
                    h_we = 1'b1; h_wa = haddr(r_slot, r_i);
                    n_ov = 1'b1;
                    n_o.event_res = EV_CMD;
                    n_o.out_char = l_rd;
                    n_o.line_length = '0;
                    n_o.cursor_pos = '0;
                    n_o.last = (r_i + 1'b1 == (LW+1)'(r_n));
                    n_i = r_i + 1'b1;
                    if (r_i + 1'b1 == (LW+1)'(r_n)) begin
                        n_st = S_IDLE;
                    end else begin
                        n_st = S_EN_R;
                    end
                end else begin
                    l_ra = LW'(r_i); // hold read data
                end
            end
            S_OUT: begin
                if (o_free) begin
                    n_ov = 1'b1;
                    n_o.event_res = r_ev;
                    n_o.out_char = '0;
                    n_o.line_length = r_len;
                    n_o.cursor_pos = r_cur;
                    n_o.last = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_len <= '0; r_cur <= '0; r_head <= '0;
            r_browse <= BW'(1); r_esc <= '0; r_mask <= '0; r_ov <= 1'b0;
            r_shr_ins <= 1'b0;
            for (int k = 0; k < HIST_SLOTS; k++) r_hlen[k] <= '0;
        end else begin
            r_st <= n_st; r_len <= n_len; r_cur <= n_cur; r_head <= n_head;
            r_browse <= n_browse; r_esc <= n_esc; r_ov <= n_ov;
            r_shr_ins <= n_shr_ins;
            if (s_cfg.valid) r_mask <= s_cfg.arrow_hook_mask;
            if (r_st == S_IDLE && s_in.valid && s_in.rx_byte == CH_CR && r_len != '0)
                r_hlen[r_head] <= r_len;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_n <= n_n; r_slot <= n_slot; r_b <= n_b; r_ev <= n_ev;
        r_o <= n_o;
    end
endmodule

/* hw/rtl/tle_checker.sv */
// Checker on the top-level ports, bound to the top level.
module tle_checker
    import tle_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] out_event,
    input logic [7:0] out_char,
    input logic [4:0] out_len,
    input logic       out_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_char))
        else $error("result changed while stalled");
    // anything but a command byte is a single, final beat with no character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_event != EV_CMD |-> out_char == 8'd0 && out_last)
        else $error("non-command beat with a character or not last");
    a_cmd_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_event == EV_CMD |-> out_len == 5'd0)
        else $error("command byte with nonzero length");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted two bytes back to back");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_event <= EV_HOOK_LT)
        else $error("event code out of range");
endmodule

bind terminal_line_editor_with_history_top tle_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_event(m_out.event_res), .out_char(m_out.out_char),
    .out_len(m_out.line_length), .out_last(m_out.last));

/* verif/tb_top.sv */
// Testbench for the terminal line editor: directed table plus random byte traffic, predicted.
module tb_top
    import tle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        t_res       res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tle_byte_if in_if();
    tle_cfg_if  cfg_if();
    tle_res_if  out_if();

    terminal_line_editor_with_history_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .s_cfg   (cfg_if),
        .m_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // Editor state as the block should hold it
    logic [7:0] line_buf [LINE_LEN];
    logic [7:0] hist_buf [HIST_SLOTS*LINE_LEN];
    int         hist_len [HIST_SLOTS];
    int         n_chars, cursor, head, browse, esc_phase;
    logic [3:0] hook_mask;

    t_res res_q [$];
    int   errors = 0;
    int   idle_pct = 29;
    int   n_bytes = 0;

    function automatic void push_res(logic [3:0] ev, logic [7:0] ch, logic lst);
        t_res r;
        r.event_res   = ev;
        r.out_char    = ch;
        r.line_length = n_chars[4:0];
        r.cursor_pos  = cursor[4:0];
        r.last        = lst;
        res_q.push_back(r);
    endfunction

    function automatic int slot_at(int age);
        return (head + HIST_SLOTS - age) % HIST_SLOTS;
    endfunction

    function automatic void recall(int age);
        int s;
        int n;
        s = slot_at(age);
        n = hist_len[s];
        if (n > LINE_LEN - 1) n = LINE_LEN - 1;
        for (int i = 0; i < n; i++) line_buf[i] = hist_buf[s*LINE_LEN + i];
        n_chars = n;
        cursor  = n;
    endfunction

    // Apply one received byte and queue the result beats it causes
    function automatic void edit_byte(logic [7:0] b);
        logic [3:0] ev;
        logic [7:0] cp [LINE_LEN];
        int len;
        ev = EV_NONE;
        if (b == CH_BS || b == CH_DEL) begin
            browse = 1;
            if (cursor > 0) begin
                for (int i = cursor - 1; i + 1 < n_chars; i++) line_buf[i] = line_buf[i+1];
                n_chars--;
                cursor--;
                ev = EV_EDIT;
            end
        end else if (b == CH_CR) begin
            len = n_chars;
            browse = 1;
            if (len > 0) begin
                for (int i = 0; i < len; i++) begin
                    cp[i] = line_buf[i];
                    hist_buf[head*LINE_LEN + i] = line_buf[i];
                end
                hist_len[head] = len;
                head = (head + 1) % HIST_SLOTS;
            end
            n_chars = 0;
            cursor = 0;
            if (len == 0) push_res(EV_EMPTY, 8'd0, 1'b1);
            else for (int i = 0; i < len; i++) push_res(EV_CMD, cp[i], i == len - 1);
            return;
        end else if (b == CH_ESC) begin
            esc_phase = 1;
        end else if (esc_phase == 1) begin
            esc_phase = (b == CH_LBR) ? 2 : 0;
        end else if (esc_phase == 2) begin
            esc_phase = 0;
            if (b == CH_A) begin
                if (hook_mask[0]) ev = EV_HOOK_UP;
                else if (browse < HISTORY_DEPTH && hist_len[slot_at(browse)] != 0) begin
                    recall(browse);
                    browse++;
                    ev = EV_EDIT;
                end
            end else if (b == CH_B) begin
                if (hook_mask[1]) ev = EV_HOOK_DN;
                else if (browse > 2) begin
                    browse--;
                    recall(browse - 1);
                    ev = EV_EDIT;
                end else if (browse == 2) begin
                    n_chars = 0;
                    cursor = 0;
                    browse = 1;
                    ev = EV_CLEAR;
                end
            end else if (b == CH_C) begin
                if (hook_mask[2]) ev = EV_HOOK_RT;
                else if (cursor < n_chars) begin cursor++; ev = EV_RIGHT; end
            end else if (b == CH_D) begin
                if (hook_mask[3]) ev = EV_HOOK_LT;
                else if (cursor > 0) begin cursor--; ev = EV_LEFT; end
            end else if (b == CH_3) begin
                esc_phase = 3;
            end
        end else if (esc_phase == 3) begin
            esc_phase = 0;
            if (b == CH_TILDE) begin
                browse = 1;
                if (cursor < n_chars) begin
                    for (int i = cursor; i + 1 < n_chars; i++) line_buf[i] = line_buf[i+1];
                    n_chars--;
                    ev = EV_EDIT;
                end
            end
        end else if (b == CH_TAB) begin
            ev = EV_NONE;
        end else if (b == CH_ETX) begin
            browse = 1;
            n_chars = 0;
            cursor = 0;
            ev = EV_ABORT;
        end else begin
            for (int i = n_chars; i > cursor; i--)
                if (i < LINE_LEN) line_buf[i] = line_buf[i-1];
            if (cursor < LINE_LEN) line_buf[cursor] = b;
            browse = 1;
            n_chars++;
            cursor++;
            if (n_chars > LINE_LEN - 1) n_chars = LINE_LEN - 1;
            if (cursor > LINE_LEN - 1) cursor = LINE_LEN - 1;
            ev = EV_EDIT;
        end
        push_res(ev, 8'd0, 1'b1);
    endfunction

    // Send one byte beat; valid stays high across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input bit typed = 0, input t_res res = '0);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        edit_byte(b);
        if (typed) begin
            void'(res_q.pop_back());
            res_q.push_back(res);
        end
        n_bytes++;
    endtask

    task automatic send_arrow(input logic [7:0] key);
        send_byte(CH_ESC);
        send_byte(CH_LBR);
        send_byte(key);
    endtask

    // Drain all results, let the sequencer settle, then write the hook mask
    task automatic set_mask(input logic [3:0] m);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.arrow_hook_mask <= m;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        hook_mask = m;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int r;
        int stop;
        logic [7:0] keys [4];
        keys = '{CH_A, CH_B, CH_C, CH_D};
        stop = n_bytes + n_items;
        while (n_bytes < stop) begin
            r = $urandom_range(99);
            if (r < 4) begin
                // fill past the end of the line
                repeat ($urandom_range(LINE_LEN + 4, LINE_LEN - 2))
                    send_byte(8'($urandom_range(126, 32)));
            end else if (r < 40) begin
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(126, 32)));
            end else if (r < 56) begin
                send_arrow(keys[$urandom_range(3)]);
            end else if (r < 62) begin
                send_arrow(CH_3);
                send_byte(CH_TILDE);
            end else if (r < 72) begin
                send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            end else if (r < 80) begin
                send_byte(CH_CR);
            end else if (r < 84) begin
                send_byte(CH_ETX);
            end else if (r < 87) begin
                send_byte(CH_TAB);
            end else if (r < 93) begin
                // broken escape sequences
                send_byte(CH_ESC);
                if ($urandom_range(1)) send_byte(CH_LBR);
                send_byte(8'($urandom));
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Result sink: check each accepted beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (res_q.size() == 0) begin
                $error("unexpected result beat: event_res %0d", out_if.event_res);
                errors++;
            end else begin
                t_res e;
                e = res_q.pop_front();
                if (out_if.event_res !== e.event_res) begin
                    $error("event_res expected %0d actual %0d", e.event_res, out_if.event_res);
                    errors++;
                end
                if (out_if.out_char !== e.out_char) begin
                    $error("out_char expected %0d actual %0d", e.out_char, out_if.out_char);
                    errors++;
                end
                if (out_if.line_length !== e.line_length) begin
                    $error("line_length expected %0d actual %0d",
                           e.line_length, out_if.line_length);
                    errors++;
                end
                if (out_if.cursor_pos !== e.cursor_pos) begin
                    $error("cursor_pos expected %0d actual %0d", e.cursor_pos, out_if.cursor_pos);
                    errors++;
                end
                if (out_if.last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, out_if.last);
                    errors++;
                end
            end
        end
        out_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_row dir_tab [26];
        dir_tab = '{
            '{CH_CR,    1, '{EV_EMPTY, 8'd0, 5'd0, 5'd0, 1'b1}},
            '{CH_BS,    1, '{EV_NONE,  8'd0, 5'd0, 5'd0, 1'b1}},
            '{CH_ESC,   0, '0}, '{CH_LBR, 0, '0}, '{CH_A, 0, '0},  // empty history
            '{8'h68,    1, '{EV_EDIT,  8'd0, 5'd1, 5'd1, 1'b1}},
            '{8'h00,    0, '0}, '{8'hff, 0, '0},                    // NUL and top byte
            '{CH_ESC,   0, '0}, '{CH_LBR, 0, '0}, '{CH_D, 0, '0},
            '{CH_ESC,   0, '0}, '{CH_LBR, 0, '0}, '{CH_3, 0, '0}, '{CH_TILDE, 0, '0},
            '{CH_TAB,   0, '0}, '{CH_DEL, 0, '0},
            '{CH_CR,    0, '0},
            '{CH_ESC,   0, '0}, '{CH_LBR, 0, '0}, '{CH_A, 0, '0},  // recall
            '{CH_ESC,   0, '0}, '{CH_LBR, 0, '0}, '{CH_B, 0, '0},  // clear
            '{CH_ESC,   0, '0},
            '{CH_ETX,   0, '0}                                      // eaten by parser
        };
        for (int i = 0; i < LINE_LEN; i++) line_buf[i] = '0;
        for (int i = 0; i < HIST_SLOTS*LINE_LEN; i++) hist_buf[i] = '0;
        for (int i = 0; i < HIST_SLOTS; i++) hist_len[i] = 0;
        n_chars = 0; cursor = 0; head = 0; browse = 1; esc_phase = 0; hook_mask = '0;
        in_if.valid = 1'b0;
        in_if.rx_byte = '0;
        cfg_if.valid = 1'b0;
        cfg_if.arrow_hook_mask = '0;
        out_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, hooks off
        foreach (dir_tab[i]) send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].res);
        send_byte(CH_ETX, 1, '{EV_ABORT, 8'd0, 5'd0, 5'd0, 1'b1});

        set_mask(4'hf);
        random_phase(60);
        set_mask(4'($urandom_range(15)));
        idle_pct = 0;
        random_phase(60);
        idle_pct = 29;
        set_mask(4'h0);
        random_phase(120);
        set_mask(4'($urandom_range(15)));
        random_phase(60);

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
